>>> rtl/ptd_pkg.sv
// ============================================================================
// ptd_pkg
// Shared types and codes for the periodic task dispatcher: table entry
// layout, request modes, result status codes and controller states.
// ============================================================================
package ptd_pkg;

   // Fixed field widths of the request and result channels
   localparam int MODE_W   = 2;
   localparam int TIME_W   = 16;
   localparam int ID_W     = 8;
   localparam int PRIO_W   = 8;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 5;

   // One table entry, as held in a cell
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] last_run;
   } entry_type;

   // Request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_DISPATCH = 3'd0,
      STAT_NONE_DUE = 3'd1,
      STAT_ADDED    = 3'd2,
      STAT_REMOVED  = 3'd3,
      STAT_FULL     = 3'd4,
      STAT_BAD_SLOT = 3'd5
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/ptd_cell.sv
// ============================================================================
// ptd_cell
// One table cell: holds a single task entry and loads its neighbor's entry
// whenever the ring advances.
// ============================================================================
module ptd_cell
   import ptd_pkg::*;
(
   input  logic      clock,
   input  logic      shift_en,
   input  entry_type entry_in,
   output entry_type entry_ff
);

   // Take the neighbor's entry on each ring step
   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

endmodule

>>> rtl/periodic_task_dispatcher.sv
// ============================================================================
// periodic_task_dispatcher
// Priority-ordered table of periodic tasks kept in a ring of cells. Most
// operations rotate the ring; the tail feed reorders entries on the way.
// ============================================================================
//
//   channel   ports    direction   transfer carries
//   -------   ------   ---------   ---------------------------------------
//   request   req_*    in          mode, now, task_id, prio, period, slot
//   result    rsp_*    out         status, id, prio, slot, occupancy, last
//
// A tick or an add rotates the ring once around and a remove runs past a full
// turn, one entry through the head cell per cycle; the FINISH state then
// delivers the final result and IDLE accepts the next request. A full-table
// add or a bad slot skips the rotation and goes straight to FINISH.
// A stalled result register pauses the rotation until it drains.
// Synchronous reset empties the table; entry contents are not cleared.
// ============================================================================
module periodic_task_dispatcher
   import ptd_pkg::*;
#(
   parameter int MAX_TASKS = 16
)
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [TIME_W-1:0]   req_now,
   input  logic [ID_W-1:0]     req_task_id,
   input  logic [PRIO_W-1:0]   req_prio,
   input  logic [TIME_W-1:0]   req_period,
   input  logic [SLOT_W-1:0]   req_slot,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_run_id,
   output logic [PRIO_W-1:0]   rsp_run_prio,
   output logic [SLOT_W-1:0]   rsp_run_slot,
   output logic [OCC_W-1:0]    rsp_occupancy,
   output logic                rsp_last
);

   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int IW = $clog2(MAX_TASKS);

   // Ring of cells
   entry_type cell_q [MAX_TASKS];
   entry_type tail_in;
   entry_type head;
   logic      shift_en;

   // Controller and request hold
   state_type             state_ff, state_in;
   mode_type              op_ff;
   status_type            fin_status_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [ID_W-1:0]       nid_ff;
   logic [PRIO_W-1:0]     nprio_ff;
   logic [TIME_W-1:0]     nper_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [CW-1:0]         step_ff;
   logic [CW-1:0]         count_ff, count_in;
   entry_type             carry_ff;
   logic                  placed_ff;

   // Pending dispatch (held back until it is known whether it is the final one)
   logic                  pend_vld_ff;
   logic [ID_W-1:0]       pend_id_ff;
   logic [PRIO_W-1:0]     pend_prio_ff;
   logic [IW-1:0]         pend_slot_ff;

   // Result register
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [PRIO_W-1:0]     rsp_prio_ff, rsp_prio_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_load;

   // Decode helpers
   logic                  req_xfer;
   logic                  out_free;
   logic [CW-1:0]         step_lim;
   logic                  sweep_last;
   logic [IW-1:0]         step_idx;
   logic                  step_live;
   logic [TIME_W-1:0]     elapsed;
   logic                  head_due;
   logic                  tick_hit;
   logic                  ins_here;
   logic                  step_in_gap;
   logic                  table_full;
   logic                  req_bad_slot;
   logic [CW+SLOT_W-1:0]  req_slot_ext, slot_ext, cnt_ext, step_ext;
   logic [IW+SLOT_W-1:0]  pend_slot_ext;
   logic [CW+OCC_W-1:0]   occ_ext;

   // Build the ring: each cell loads from its upper neighbor, the top from the feed
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      if (i == MAX_TASKS - 1) begin : g_top
         ptd_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .entry_in (tail_in),
            .entry_ff (cell_q[i])
         );
      end else begin : g_mid
         ptd_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .entry_in (cell_q[i+1]),
            .entry_ff (cell_q[i])
         );
      end
   end

   assign head = cell_q[0];

   // Decode the current step
   assign req_xfer     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign step_lim     = (op_ff == MODE_REMOVE) ? CW'(MAX_TASKS) : CW'(MAX_TASKS - 1);
   assign sweep_last   = (step_ff == step_lim);
   assign step_idx     = step_ff[IW-1:0];
   assign step_live    = (step_ff < count_ff);
   assign elapsed      = now_ff - head.last_run;
   assign head_due     = (elapsed >= head.period);
   assign tick_hit     = (op_ff == MODE_TICK) && step_live && head_due;
   assign ins_here     = (op_ff == MODE_ADD) && !placed_ff
                         && (!step_live || (head.prio > nprio_ff));
   assign req_slot_ext = {{CW{1'b0}}, req_slot};
   assign slot_ext     = {{CW{1'b0}}, slot_ff};
   assign cnt_ext      = {{SLOT_W{1'b0}}, count_ff};
   assign step_ext     = {{SLOT_W{1'b0}}, step_ff};
   assign step_in_gap  = (step_ff != '0) && (step_ext <= slot_ext);
   assign table_full   = (count_ff == CW'(MAX_TASKS));
   assign req_bad_slot = (req_slot_ext >= cnt_ext);
   assign pend_slot_ext = {{SLOT_W{1'b0}}, pend_slot_ff};

   // Select what enters the top of the ring
   always_comb begin
      tail_in = head;
      unique case (op_ff)
         MODE_TICK: begin
            if (tick_hit) begin
               tail_in.last_run = now_ff;
            end
         end
         MODE_ADD: begin
            if (placed_ff) begin
               tail_in = carry_ff;
            end else if (ins_here) begin
               tail_in.id       = nid_ff;
               tail_in.prio     = nprio_ff;
               tail_in.period   = nper_ff;
               tail_in.last_run = '0;
            end
         end
         MODE_REMOVE: begin
            if (step_in_gap) begin
               tail_in = carry_ff;
            end
         end
         default: begin
            tail_in = head;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (mode_type'(req_mode))
                  MODE_TICK:   state_in = ST_SWEEP;
                  MODE_ADD:    state_in = table_full ? ST_FINISH : ST_SWEEP;
                  MODE_REMOVE: state_in = req_bad_slot ? ST_FINISH : ST_SWEEP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (out_free && sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Table size after the final result
   always_comb begin
      count_in = count_ff;
      if ((state_ff == ST_FINISH) && out_free) begin
         if (fin_status_ff == STAT_ADDED) begin
            count_in = count_ff + CW'(1);
         end else if (fin_status_ff == STAT_REMOVED) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   assign occ_ext = {{OCC_W{1'b0}}, count_in};

   // Outputs: handshake, ring advance and result contents
   always_comb begin
      req_ready     = 1'b0;
      shift_en      = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_DISPATCH;
      rsp_id_in     = pend_id_ff;
      rsp_prio_in   = pend_prio_ff;
      rsp_slot_in   = pend_slot_ext[SLOT_W-1:0];
      rsp_occ_in    = occ_ext[OCC_W-1:0];
      rsp_last_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SWEEP: begin
            shift_en = out_free;
            rsp_load = out_free && tick_hit && pend_vld_ff;
         end
         ST_FINISH: begin
            rsp_load    = out_free;
            rsp_last_in = 1'b1;
            unique case (fin_status_ff)
               STAT_NONE_DUE: begin
                  if (!pend_vld_ff) begin
                     rsp_status_in = STAT_NONE_DUE;
                     rsp_id_in     = '0;
                     rsp_prio_in   = '0;
                     rsp_slot_in   = '0;
                  end
               end
               STAT_ADDED: begin
                  rsp_status_in = STAT_ADDED;
                  rsp_id_in     = nid_ff;
                  rsp_prio_in   = nprio_ff;
               end
               STAT_REMOVED, STAT_BAD_SLOT: begin
                  rsp_status_in = fin_status_ff;
                  rsp_id_in     = '0;
                  rsp_prio_in   = '0;
                  rsp_slot_in   = slot_ff;
               end
               default: begin
                  rsp_status_in = fin_status_ff;
                  rsp_id_in     = '0;
                  rsp_prio_in   = '0;
                  rsp_slot_in   = '0;
               end
            endcase
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         placed_ff    <= 1'b0;
         op_ff        <= MODE_NONE;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         // Hold the result until the consumer takes it
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_xfer) begin
            op_ff       <= mode_type'(req_mode);
            pend_vld_ff <= 1'b0;
            placed_ff   <= 1'b0;
         end else if (shift_en) begin
            if (tick_hit) begin
               pend_vld_ff <= 1'b1;
            end
            if (ins_here) begin
               placed_ff <= 1'b1;
            end
         end
      end
   end

   // Request hold, step counter and pending dispatch
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         now_ff   <= req_now;
         nid_ff   <= req_task_id;
         nprio_ff <= req_prio;
         nper_ff  <= req_period;
         slot_ff  <= req_slot;
         step_ff  <= '0;
         unique case (mode_type'(req_mode))
            MODE_ADD:    fin_status_ff <= table_full ? STAT_FULL : STAT_ADDED;
            MODE_REMOVE: fin_status_ff <= req_bad_slot ? STAT_BAD_SLOT : STAT_REMOVED;
            default:     fin_status_ff <= STAT_NONE_DUE;
         endcase
      end else if (shift_en) begin
         step_ff  <= step_ff + CW'(1);
         carry_ff <= head;
         if (tick_hit) begin
            pend_id_ff   <= head.id;
            pend_prio_ff <= head.prio;
            pend_slot_ff <= step_idx;
         end
         if (ins_here) begin
            pend_slot_ff <= step_idx;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_occ_ff    <= rsp_occ_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_run_id    = rsp_id_ff;
   assign rsp_run_prio  = rsp_prio_ff;
   assign rsp_run_slot  = rsp_slot_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // Table never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS))
      else $error("task count above capacity");

   // Sweep step stays within one rotation
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (step_ff <= CW'(MAX_TASKS)))
      else $error("sweep step past rotation length");

   // Dispatches delivered during a sweep are never the final result
   a_mid_not_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && rsp_load) |=> (rsp_valid_ff && !rsp_last_ff))
      else $error("final flag set inside sweep");

   // Closing transfer always carries the final flag
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("closing result without final flag");

   // An add that reaches its final result has placed the new entry
   a_add_placed: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && (fin_status_ff == STAT_ADDED)) |-> placed_ff)
      else $error("add finished without inserting");
`endif

endmodule
